>>> rtl/bfd_pkg.sv
// ============================================================================
// bfd_pkg : shared types and constants of the box filter downscaler
// Result record passed from the accumulator to the divider, queue depth and
// the reciprocal table used to divide a block sum by the block area.
// ============================================================================
`default_nettype none

package bfd_pkg;

    localparam int DIV_IN_W    = 16;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_IDX_W = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BLOCK = 8;
    localparam logic [3:0]  BLOCK_SIZE_RST   = 4'd2;
    localparam logic [12:0] SOURCE_WIDTH_RST = 13'd640;

    typedef enum logic [0:0] {
        REG_BLOCK_SIZE   = 1'b0,
        REG_SOURCE_WIDTH = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [DIV_IN_W-1:0] red_sum;
        logic [DIV_IN_W-1:0] green_sum;
        logic [DIV_IN_W-1:0] blue_sum;
        logic                row_end;
    } result_t;

    // ceil(2^24 / (n*n)); exact quotient for any 16-bit sum
    function automatic logic [RECIP_W-1:0] recip(input logic [RECIP_IDX_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd1864136;
            5'd4:    r = 25'd1048576;
            5'd5:    r = 25'd671089;
            5'd6:    r = 25'd466034;
            5'd7:    r = 25'd342393;
            5'd8:    r = 25'd262144;
            5'd9:    r = 25'd207127;
            5'd10:   r = 25'd167773;
            5'd11:   r = 25'd138655;
            5'd12:   r = 25'd116509;
            5'd13:   r = 25'd99274;
            5'd14:   r = 25'd85599;
            5'd15:   r = 25'd74566;
            5'd16:   r = 25'd65536;
            default: r = 25'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bfd_ram.sv
// ============================================================================
// bfd_ram : generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module bfd_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfd_front.sv
// ============================================================================
// bfd_front : raster position tracking and column sum accumulation
// Classifies each source pixel by block position, accumulates it into the
// line store and emits a result record when a block completes.
// ============================================================================
`default_nettype none

module bfd_front #(
    parameter int MAX_WIDTH = bfd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = bfd_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             restart,
    input  wire logic [$clog2(MAX_BLOCK+1)-1:0]   n,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   w,
    input  wire logic                             push,
    input  wire logic                             full,
    input  wire logic [7:0]                       red_in,
    input  wire logic [7:0]                       green_in,
    input  wire logic [7:0]                       blue_in,
    output logic                                  pend,
    output bfd_pkg::result_t                      q_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH+1);
    localparam int EW    = CW + 1;
    localparam int BW    = $clog2(MAX_BLOCK);
    localparam int NW    = $clog2(MAX_BLOCK+1);
    localparam int SUM_W = $clog2(255*MAX_BLOCK*MAX_BLOCK+1);
    localparam int MEM_W = 3*SUM_W;

    logic [AW-1:0] col_reg, col_next;
    logic [BW-1:0] k_reg, k_next;
    logic [BW-1:0] r_reg, r_next;
    logic [CW-1:0] start_reg, start_next;
    logic [AW-1:0] d_reg, d_next;

    logic             s1_valid_reg;
    logic             s1_wr_reg;
    logic             s1_last_reg;
    logic             s1_row_end_reg;
    logic             s1_fresh_reg;
    logic [AW-1:0]    s1_d_reg;
    logic [7:0]       s1_red_reg, s1_green_reg, s1_blue_reg;
    logic             byp_valid_reg;
    logic [MEM_W-1:0] byp_data_reg;

    logic             accept;
    logic [EW-1:0]    s_plus_n;
    logic             in_blk, row_last, k_last, r_last, fresh, row_wrap, byp_hit;
    logic [MEM_W-1:0] rdata, base, wdata;
    logic [SUM_W-1:0] red_sum, green_sum, blue_sum;

    assign accept   = push && !full;
    assign s_plus_n = EW'(start_reg) + EW'(n);
    assign in_blk   = s_plus_n <= EW'(w);
    assign row_last = (s_plus_n + EW'(n)) > EW'(w);
    assign k_last   = (NW'(k_reg) + NW'(1)) == n;
    assign r_last   = (NW'(r_reg) + NW'(1)) == n;
    assign fresh    = (k_reg == '0) && (r_reg == '0);
    assign row_wrap = (EW'(col_reg) + EW'(1)) >= EW'(w);

    always_comb
    begin
        col_next   = col_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        start_next = start_reg;
        d_next     = d_reg;
        if (restart)
        begin
            col_next   = '0;
            k_next     = '0;
            r_next     = '0;
            start_next = '0;
            d_next     = '0;
        end
        else if (accept)
        begin
            if (in_blk)
            begin
                if (k_last)
                begin
                    k_next     = '0;
                    start_next = CW'(s_plus_n);
                    d_next     = d_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            if (row_wrap)
            begin
                col_next   = '0;
                k_next     = '0;
                start_next = '0;
                d_next     = '0;
                r_next     = r_last ? '0 : r_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            k_reg        <= '0;
            r_reg        <= '0;
            start_reg    <= '0;
            d_reg        <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            k_reg        <= k_next;
            r_reg        <= r_next;
            start_reg    <= start_next;
            d_reg        <= d_next;
            s1_valid_reg <= accept;
        end
    end

    // same column written back while it is read again: take the new sum
    assign byp_hit = s1_valid_reg && s1_wr_reg && (s1_d_reg == d_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_wr_reg      <= in_blk;
            s1_last_reg    <= in_blk && k_last && r_last;
            s1_row_end_reg <= row_last;
            s1_fresh_reg   <= fresh;
            s1_d_reg       <= d_reg;
            s1_red_reg     <= red_in;
            s1_green_reg   <= green_in;
            s1_blue_reg    <= blue_in;
            byp_valid_reg  <= byp_hit;
            byp_data_reg   <= wdata;
        end
    end

    bfd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg && s1_wr_reg),
        .waddr (s1_d_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (d_reg),
        .rdata (rdata)
    );

    // first pixel of each block starts from zero
    always_comb
    begin
        if (s1_fresh_reg)
        begin
            base = '0;
        end
        else if (byp_valid_reg)
        begin
            base = byp_data_reg;
        end
        else
        begin
            base = rdata;
        end
    end

    assign red_sum   = base[3*SUM_W-1:2*SUM_W] + SUM_W'(s1_red_reg);
    assign green_sum = base[2*SUM_W-1:SUM_W]   + SUM_W'(s1_green_reg);
    assign blue_sum  = base[SUM_W-1:0]         + SUM_W'(s1_blue_reg);
    assign wdata     = {red_sum, green_sum, blue_sum};

    assign pend              = s1_valid_reg && s1_last_reg;
    assign q_data.red_sum    = bfd_pkg::DIV_IN_W'(red_sum);
    assign q_data.green_sum  = bfd_pkg::DIV_IN_W'(green_sum);
    assign q_data.blue_sum   = bfd_pkg::DIV_IN_W'(blue_sum);
    assign q_data.row_end    = s1_row_end_reg;

    a_last_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        pend |-> s1_wr_reg)
        else $error("block completion outside a full block");

endmodule

`default_nettype wire

>>> rtl/bfd_queue.sv
// ============================================================================
// bfd_queue : short result queue between accumulator and divider
// Register-based FIFO with level output.
// ============================================================================
`default_nettype none

module bfd_queue #(
    parameter int DEPTH = bfd_pkg::QUEUE_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire bfd_pkg::result_t           data,
    input  wire logic                       pop,
    output bfd_pkg::result_t                head,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    bfd_pkg::result_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= data;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign level = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == LW'(DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("result queue underflow");

endmodule

`default_nettype wire

>>> rtl/bfd_back.sv
// ============================================================================
// bfd_back : block average and output stage
// Divides the three block sums by the block area through a reciprocal
// multiply and holds the result transaction until it is popped.
// ============================================================================
`default_nettype none

module bfd_back #(
    parameter int MAX_BLOCK = bfd_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [$clog2(MAX_BLOCK+1)-1:0] n,
    input  wire logic                           q_empty,
    input  wire bfd_pkg::result_t               q_head,
    output logic                                q_pop,
    output logic [7:0]                          red_out,
    output logic [7:0]                          green_out,
    output logic [7:0]                          blue_out,
    output logic                                row_end,
    output logic                                empty,
    input  wire logic                           pop
);

    localparam int PROD_W = bfd_pkg::DIV_IN_W + bfd_pkg::RECIP_W;
    localparam int SH     = bfd_pkg::RECIP_SHIFT;

    logic [bfd_pkg::RECIP_W-1:0] rcp;
    logic [PROD_W-1:0]           red_prod, green_prod, blue_prod;
    logic                        out_valid_reg;

    assign rcp        = bfd_pkg::recip(bfd_pkg::RECIP_IDX_W'(n));
    assign red_prod   = PROD_W'(q_head.red_sum)   * PROD_W'(rcp);
    assign green_prod = PROD_W'(q_head.green_sum) * PROD_W'(rcp);
    assign blue_prod  = PROD_W'(q_head.blue_sum)  * PROD_W'(rcp);

    assign q_pop = !q_empty && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            red_out   <= red_prod[SH+7:SH];
            green_out <= green_prod[SH+7:SH];
            blue_out  <= blue_prod[SH+7:SH];
            row_end   <= q_head.row_end;
        end
    end

    assign empty = !out_valid_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> rtl/box_filter_downscale_unit.sv
// ============================================================================
// box_filter_downscale_unit : N by N box filter image downscaler
// Source RGB pixels enter on a push/full channel in raster order. Each
// complete N by N block is averaged (sum / N*N, truncated) and the result
// leaves on an empty/pop channel together with a row_end flag on the last
// destination pixel of a row. Partial blocks at the right or bottom edge
// give nothing.
// Throughput is one pixel per cycle while full is low, set by the line store
// read-modify-write loop (registered read, accumulate, same-column bypass).
// A block's last pixel passes the accumulate stage, queue and output register
// before empty goes low. If pop is held low, finished results collect in a
// four-entry queue; full rises when it and the accumulate stage are taken.
// Reset sets block_size to 2 and source_width to 640 and restarts the frame;
// the line store needs no clearing pass, the first row of each block row
// starts its column sums from zero. A write to either register over the
// APB port (block_size at 0x0, source_width at 0x4) restarts the frame.
// ============================================================================
`default_nettype none

module box_filter_downscale_unit #(
    parameter int MAX_WIDTH = bfd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = bfd_pkg::DEF_MAX_BLOCK
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic             row_end
);

    localparam int CW = $clog2(MAX_WIDTH+1);
    localparam int NW = $clog2(MAX_BLOCK+1);
    localparam int QD = bfd_pkg::QUEUE_DEPTH;
    localparam int LW = $clog2(QD+1);

    logic [3:0]  block_size_reg;
    logic [12:0] source_width_reg;
    logic        wr;
    bfd_pkg::reg_index_t idx;

    logic [NW-1:0]    n_eff;
    logic [CW-1:0]    w_eff;
    logic             pend, q_pop, q_empty;
    logic [LW-1:0]    q_level;
    bfd_pkg::result_t q_data, q_head;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = bfd_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg   <= bfd_pkg::BLOCK_SIZE_RST;
            source_width_reg <= bfd_pkg::SOURCE_WIDTH_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                bfd_pkg::REG_BLOCK_SIZE:   block_size_reg   <= pwdata[3:0];
                bfd_pkg::REG_SOURCE_WIDTH: source_width_reg <= pwdata[12:0];
                default:                   block_size_reg   <= block_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bfd_pkg::REG_BLOCK_SIZE:   prdata = 32'(block_size_reg);
            bfd_pkg::REG_SOURCE_WIDTH: prdata = 32'(source_width_reg);
            default:                   prdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (block_size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(block_size_reg) > MAX_BLOCK)
        begin
            n_eff = NW'(MAX_BLOCK);
        end
        else
        begin
            n_eff = NW'(block_size_reg);
        end
    end

    always_comb
    begin
        priority if (source_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(source_width_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(source_width_reg);
        end
    end

    assign full = ((LW+1)'(q_level) + (LW+1)'(pend)) >= (LW+1)'(QD);

    bfd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (wr),
        .n        (n_eff),
        .w        (w_eff),
        .push     (push),
        .full     (full),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .pend     (pend),
        .q_data   (q_data)
    );

    bfd_queue #(
        .DEPTH (QD)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (pend),
        .data  (q_data),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .level (q_level)
    );

    bfd_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n_eff),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .row_end   (row_end),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire
